[sv/sads_pkg.sv]
// ---------------------------------------------------------------------------
// sads_pkg: shared types and codes for the dual stack
// Opcode and status codes, controller state type, and the command and
// status structs between controller and datapath.
// ---------------------------------------------------------------------------
package sads_pkg;

    // Input field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // opcode field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // stack_select field
    localparam logic SEL_LOW  = 1'b0;
    localparam logic SEL_HIGH = 1'b1;

    // status field
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [0:0] {
        CS_IDLE,
        CS_READ
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // input item accepted this cycle
        logic load_rd;  // move read data into the output register
    } sads_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_valid;  // output register holds an item
        logic pop_go;     // current input is a pop that will read memory
    } sads_stat_t;

endpackage

[sv/shared_array_dual_stack.sv]
// ---------------------------------------------------------------------------
// shared_array_dual_stack: two stacks in one shared memory
// Results: a push or refused access is registered into the output register;
//   a successful pop passes through the memory read register first.
// Throughput: one push per cycle while the output is not stalled; no new item
//   is taken while a pop waits on the registered read of the single-port memory.
// Reset: aresetn (synchronous, active low) empties both stacks and the
//   output register; memory contents are not cleared and need no pass.
// ---------------------------------------------------------------------------
module shared_array_dual_stack #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sads_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic [1:0]                      s_tuser,   // [0] opcode, [1] stack_select
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sads_pkg::VALUE_W-1:0]    m_tdata,   // [31:0] pop_value
    output logic [sads_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
    import sads_pkg::*;

    // controller <-> datapath
    sads_cmd_t  cmd;
    sads_stat_t stat;

    // Controller: gates acceptance on a free (or draining) output register
    // and sequences the registered memory read of a pop.
    sads_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: memory, both fill counters, full/empty checks and the
    // output register that decouples the result side.
    sads_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[sv/sads_ctrl.sv]
// ---------------------------------------------------------------------------
// sads_ctrl: dual stack controller
// Accepts one item at a time; a successful pop holds off new input while
// waiting on the registered memory read.
// ---------------------------------------------------------------------------
module sads_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    input  sads_pkg::sads_stat_t stat,
    output sads_pkg::sads_cmd_t  cmd
);
    import sads_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (cmd.take && stat.pop_go) begin
                    state_next = CS_READ;
                end
            end
            CS_READ: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = 1'b0;
        cmd.take    = 1'b0;
        cmd.load_rd = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready = !stat.out_valid || m_tready;
                cmd.take = s_tvalid && s_tready;
            end
            CS_READ: begin
                cmd.load_rd = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // a memory read always completes in the very next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_READ) |=> (state_reg == CS_IDLE))
        else $error("controller stayed in read state");

    // a reading pop always goes through the read state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && stat.pop_go) |=> cmd.load_rd)
        else $error("pop read data was not loaded");

endmodule

[sv/sads_datapath.sv]
// ---------------------------------------------------------------------------
// sads_datapath: dual stack storage, fill counters and output register
// One memory shared by both stacks, lower stack from word 0 upward,
// upper stack from the last word downward.
// ---------------------------------------------------------------------------
module sads_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sads_pkg::sads_cmd_t                 cmd,
    output sads_pkg::sads_stat_t                stat,
    input  logic [sads_pkg::VALUE_W-1:0]        s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sads_pkg::VALUE_W-1:0]        m_tdata,
    output logic [sads_pkg::STATUS_W-1:0]       m_tuser
);
    import sads_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW:0]   DEPTH_SUM = (FW + 1)'(DEPTH);
    localparam logic [FW-1:0] TOP_WORD  = FW'(DEPTH - 1);
    localparam logic [FW-1:0] TOP_END   = FW'(DEPTH);
    localparam logic [FW-1:0] FILL_ONE  = FW'(1);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [FW-1:0]       low_fill_reg,  low_fill_next;
    logic [FW-1:0]       high_fill_reg, high_fill_next;
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                m_valid_reg,   m_valid_next;
    logic [VALUE_W-1:0]  m_data_reg,    m_data_next;
    logic [STATUS_W-1:0] m_stat_reg,    m_stat_next;

    logic          in_op;
    logic          in_sel;
    logic          is_full;
    logic          sel_empty;
    logic          wr_en;
    logic          rd_en;
    logic [FW-1:0] wr_pos;
    logic [FW-1:0] rd_pos;

    assign in_op     = s_tuser[0];
    assign in_sel    = s_tuser[1];
    assign is_full   = ({1'b0, low_fill_reg} + {1'b0, high_fill_reg}) >= DEPTH_SUM;
    assign sel_empty = (in_sel == SEL_LOW) ? (low_fill_reg == '0) : (high_fill_reg == '0);

    assign stat.pop_go    = (in_op == OP_POP) && !sel_empty;
    assign stat.out_valid = m_valid_reg;

    assign wr_en  = cmd.take && (in_op == OP_PUSH) && !is_full;
    assign rd_en  = cmd.take && stat.pop_go;
    assign wr_pos = (in_sel == SEL_LOW) ? low_fill_reg : (TOP_WORD - high_fill_reg);
    assign rd_pos = (in_sel == SEL_LOW) ? (low_fill_reg - FILL_ONE)
                                        : (TOP_END - high_fill_reg);

    // fill counters and output register next values
    always_comb begin
        low_fill_next  = low_fill_reg;
        high_fill_next = high_fill_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_stat_next    = m_stat_reg;
        if (cmd.take) begin
            if (in_op == OP_PUSH) begin
                m_valid_next = 1'b1;
                m_data_next  = '0;
                if (is_full) begin
                    m_stat_next = STAT_FULL;
                end else begin
                    m_stat_next = STAT_OK;
                    if (in_sel == SEL_LOW) begin
                        low_fill_next = low_fill_reg + FILL_ONE;
                    end else begin
                        high_fill_next = high_fill_reg + FILL_ONE;
                    end
                end
            end else if (sel_empty) begin
                m_valid_next = 1'b1;
                m_data_next  = '0;
                m_stat_next  = STAT_EMPTY;
            end else begin
                if (in_sel == SEL_LOW) begin
                    low_fill_next = low_fill_reg - FILL_ONE;
                end else begin
                    high_fill_next = high_fill_reg - FILL_ONE;
                end
            end
        end
        if (cmd.load_rd) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_data_reg;
            m_stat_next  = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_fill_reg  <= '0;
            high_fill_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            low_fill_reg  <= low_fill_next;
            high_fill_reg <= high_fill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_stat_reg <= m_stat_next;
    end

    // shared memory: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_pos[AW-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_pos[AW-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

    // the two stacks never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, low_fill_reg} + {1'b0, high_fill_reg}) <= DEPTH_SUM)
        else $error("stacks overlap");

    // read data is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_rd |-> !m_valid_reg)
        else $error("output register overwritten by read data");

    // status code three is never presented
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_stat_reg == STAT_OK || m_stat_reg == STAT_FULL ||
                         m_stat_reg == STAT_EMPTY))
        else $error("undefined status code");

    // a failed access leaves both fill counters alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && !wr_en && !rd_en) |=>
            ($stable(low_fill_reg) && $stable(high_fill_reg)))
        else $error("fill count changed on a refused access");

endmodule
